[design/mcsl_pkg.sv]
// Shared types, constants and the output width correction for the servo slew limiter.
// No dependencies; imported by every module of the block.
package mcsl_pkg;

  localparam int DIV_DW = 20;
  localparam int DIV_VW = 10;

  localparam logic [11:0] MIN_PULSE_RST = 12'd544;
  localparam logic [11:0] MAX_PULSE_RST = 12'd2400;
  localparam logic [9:0]  FRAME_RATE_RST = 10'd50;
  localparam logic [7:0]  FULL_ANGLE = 8'd180;
  localparam logic [16:0] MIN_STEP = 17'd2;

  // x / 180 as (x >> 2) * ceil(2^24 / 45) >> 24, exact for x below 2^20
  localparam logic [18:0] RECIP_45 = 19'd372828;
  localparam int          RECIP_SHIFT = 24;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_MOVE_NOW   = 3'd1,
    CMD_MOVE_SPEED = 3'd2,
    CMD_DETACH     = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_COUNT   = 3'd0,
    CFG_MIN     = 3'd1,
    CFG_MAX     = 3'd2,
    CFG_RATE    = 3'd3,
    CFG_REVERSE = 3'd4,
    CFG_OFFSET  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  ch;
    logic [11:0] pulse;
    logic        valid;
    logic        moving;
  } res_t;

  typedef struct packed {
    logic commit;
    logic all_idle;
  } commit_t;

  // offset, optional mirror about the centre, saturate to 0..4095
  function automatic logic [11:0] emit_width(logic [11:0] w, logic [7:0] off, logic rev,
                                             logic [11:0] mn, logic [11:0] mx);
    logic signed [14:0] v;
    logic [11:0] r;
    v = $signed({3'b000, w}) + $signed({{7{off[7]}}, off});
    if (rev) begin
      v = $signed({3'b000, mn}) + $signed({3'b000, mx}) - v;
    end
    if (v < 0) begin
      r = '0;
    end else if (v > 15'sd4095) begin
      r = 12'hFFF;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

endpackage

[design/multi_channel_servo_slew_limiter.sv]
// Top level of the servo slew limiter: command sequencer, per-channel state memory,
// configuration registers. Depends on mcsl_pkg, mcsl_div and mcsl_outbuf.
//
// Usage: items enter on in_valid_i/in_stall_o (cmd, channel, angle, speed) and
// results leave on out_valid_o/out_stall_i, last_o marking the final result of
// an item. Registers are written on cfg_valid_i/cfg_ready_o (always ready); the
// user must write them only while the block is idle, and the block itself does not
// enforce this. One item is worked at a time; a new item is taken once the previous
// one is finished and its results have left the result buffer (the last may still
// sit in the output register).
// A frame tick visits each counted channel: one without a target is passed over, one
// whose position is unknown jumps to its target, and one that steps takes a pass of
// the serial divider; a tick that serves no channel still gives one result.
// The first result reaches the outputs once the commit state has set the buffer busy
// and the output register has loaded it, then one per cycle while out_stall_i is low;
// a stall holds the output register and the buffer behind it.
// Reset: all channel positions unknown, registers at 0, 544, 2400, 50, 0, 0.
module multi_channel_servo_slew_limiter import mcsl_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [2:0]  channel_i,
  input  logic [7:0]  angle_i,
  input  logic [11:0] speed_dps_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_channel_o,
  output logic [11:0] pulse_us_o,
  output logic        pulse_valid_o,
  output logic        channel_moving_o,
  output logic        all_idle_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNTW = $clog2(CHANNELS + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_UPD    = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_MOD    = 9'b000001000,
    S_DIV    = 9'b000010000,
    S_WB     = 9'b000100000,
    S_ANG    = 9'b001000000,
    S_CMD    = 9'b010000000,
    S_COMMIT = 9'b100000000
  } state_e;

  typedef struct packed {
    logic [11:0] cur;
    logic [11:0] tgt;
    logic [11:0] spd;
  } ent_t;

  // configuration
  logic [3:0]  count_q;
  logic [11:0] min_q, max_q;
  logic [9:0]  rate_q;
  logic [7:0]  rev_q;
  logic [63:0] off_q;

  // control
  state_e          state_q, state_d;
  logic [CNTW-1:0] idx_q, idx_d, k_q, k_d;
  logic [CHANNELS-1:0] ck_q, ck_d, tk_q, tk_d, idle_q, idle_d;
  logic [4:0]  upd_q, upd_d;
  logic [11:0] w_q, w_d;
  logic [2:0]  cmd_q, ch_q;
  logic [11:0] spd_q;
  logic        ch_ok_q;

  // division by 180
  logic [19:0] num_q, num_d;
  logic [36:0] recip_p;
  logic [11:0] quo180;

  // memory
  ent_t        state_mem [CHANNELS];
  ent_t        rd_q;
  logic        mem_re, mem_we;
  logic [CHW-1:0] mem_raddr, mem_waddr;
  ent_t        mem_wdata;

  // divider
  logic              div_start, div_done;
  logic [DIV_DW-1:0] div_dividend, div_q;
  logic [DIV_VW-1:0] div_divisor;

  // result buffer
  logic            ob_we, ob_busy;
  logic [CHW-1:0]  ob_idx;
  res_t            ob_res;
  commit_t         ob_commit;

  logic            acc;
  logic            ch_ok;
  logic [CNTW-1:0] n_cnt;
  logic [CHANNELS-1:0] cnt_mask;
  logic [7:0]      ang_c;
  logic [11:0]     adiff;
  logic [CHW-1:0]  row, irow;
  logic [16:0]     step;
  logic [11:0]     delta;
  logic [11:0]     new_c;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= MIN_PULSE_RST;
      max_q   <= MAX_PULSE_RST;
      rate_q  <= FRAME_RATE_RST;
      rev_q   <= '0;
      off_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_COUNT:   count_q <= cfg_data_i[3:0];
        CFG_MIN:     min_q   <= cfg_data_i[11:0];
        CFG_MAX:     max_q   <= cfg_data_i[11:0];
        CFG_RATE:    rate_q  <= cfg_data_i[9:0];
        CFG_REVERSE: rev_q   <= cfg_data_i[7:0];
        CFG_OFFSET:  off_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE) || ob_busy;
  assign acc        = in_valid_i && !in_stall_o;
  assign ch_ok      = int'(channel_i) < CHANNELS;
  assign n_cnt      = (int'(count_q) > CHANNELS) ? CNTW'(CHANNELS) : CNTW'(count_q);
  assign ang_c      = (angle_i > FULL_ANGLE) ? FULL_ANGLE : angle_i;
  assign adiff      = (max_q >= min_q) ? (max_q - min_q) : (min_q - max_q);
  assign row        = ch_q[CHW-1:0];
  assign irow       = idx_q[CHW-1:0];

  // numerator taken with the item: span for a tick, angle times span for a move
  assign num_d   = (cmd_e'(cmd_i) == CMD_TICK)
                   ? 20'((max_q > min_q) ? (max_q - min_q) : 12'd0)
                   : 20'(ang_c) * 20'(adiff);
  assign recip_p = {19'b0, num_q[19:2]} * {18'b0, RECIP_45};
  assign quo180  = 12'(recip_p >> RECIP_SHIFT);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      cnt_mask[i] = (i < int'(n_cnt));
    end
  end

  // slew step toward the target
  always_comb begin
    step = (div_q[16:0] < MIN_STEP) ? MIN_STEP : div_q[16:0];
    delta = '0;
    new_c = rd_q.cur;
    if (rd_q.tgt > rd_q.cur) begin
      delta = rd_q.tgt - rd_q.cur;
      new_c = ({5'b0, delta} > step) ? (rd_q.cur + step[11:0]) : rd_q.tgt;
    end else if (rd_q.tgt < rd_q.cur) begin
      delta = rd_q.cur - rd_q.tgt;
      new_c = ({5'b0, delta} > step) ? (rd_q.cur - step[11:0]) : rd_q.tgt;
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    k_d          = k_q;
    ck_d         = ck_q;
    tk_d         = tk_q;
    idle_d       = idle_q;
    upd_d        = upd_q;
    w_d          = w_q;
    mem_re       = 1'b0;
    mem_raddr    = irow;
    mem_we       = 1'b0;
    mem_waddr    = irow;
    mem_wdata    = rd_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    ob_we        = 1'b0;
    ob_idx       = k_q[CHW-1:0];
    ob_res       = '{ch: ch_q, pulse: '0, valid: 1'b0, moving: 1'b0};
    ob_commit    = '{commit: 1'b0, all_idle: &(idle_q | ~cnt_mask)};

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          idx_d = '0;
          k_d   = '0;
          if (cmd_e'(cmd_i) == CMD_TICK) begin
            state_d = S_UPD;
          end else if (!ch_ok) begin
            state_d = S_CMD;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = channel_i[CHW-1:0];
            if (cmd_e'(cmd_i) == CMD_MOVE_NOW || cmd_e'(cmd_i) == CMD_MOVE_SPEED) begin
              state_d = S_ANG;
            end else begin
              state_d = S_CMD;
            end
          end
        end
      end
      S_UPD: begin
        upd_d   = quo180[4:0];
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (idx_q >= n_cnt) begin
          if (k_q == '0) begin
            ob_we  = 1'b1;
            ob_res = '{ch: 3'd0, pulse: '0, valid: 1'b0, moving: 1'b0};
            k_d    = CNTW'(1);
          end
          state_d = S_COMMIT;
        end else if (tk_q[irow]) begin
          mem_re  = 1'b1;
          state_d = S_MOD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_MOD: begin
        if (!ck_q[irow]) begin
          w_d     = rd_q.tgt;
          state_d = S_WB;
        end else begin
          div_start    = 1'b1;
          div_dividend = DIV_DW'(rd_q.spd) * DIV_DW'(upd_q);
          div_divisor  = (rate_q == '0) ? DIV_VW'(1) : rate_q;
          state_d      = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          w_d     = new_c;
          state_d = S_WB;
        end
      end
      S_WB: begin
        mem_we       = 1'b1;
        mem_wdata    = '{cur: w_q, tgt: rd_q.tgt, spd: rd_q.spd};
        ck_d[irow]   = 1'b1;
        idle_d[irow] = (w_q == rd_q.tgt);
        ob_we        = 1'b1;
        ob_res       = '{ch: 3'(irow),
                         pulse: emit_width(w_q, off_q[{irow, 3'b000} +: 8], rev_q[irow],
                                           min_q, max_q),
                         valid: 1'b1, moving: (w_q != rd_q.tgt)};
        k_d          = k_q + 1'b1;
        idx_d        = idx_q + 1'b1;
        state_d      = S_SCAN;
      end
      S_ANG: begin
        w_d     = (max_q >= min_q) ? (min_q + quo180) : (min_q - quo180);
        state_d = S_CMD;
      end
      S_CMD: begin
        ob_we     = 1'b1;
        ob_idx    = '0;
        k_d       = CNTW'(1);
        mem_waddr = row;
        if (ch_ok_q) begin
          unique case (cmd_q)
            CMD_MOVE_NOW: begin
              mem_we       = 1'b1;
              mem_wdata    = '{cur: w_q, tgt: w_q, spd: rd_q.spd};
              ck_d[row]    = 1'b1;
              tk_d[row]    = 1'b1;
              idle_d[row]  = 1'b1;
              ob_res.pulse = emit_width(w_q, off_q[{row, 3'b000} +: 8], rev_q[row],
                                        min_q, max_q);
              ob_res.valid = 1'b1;
            end
            CMD_MOVE_SPEED: begin
              mem_we        = 1'b1;
              mem_wdata     = '{cur: rd_q.cur, tgt: w_q, spd: spd_q};
              tk_d[row]     = 1'b1;
              idle_d[row]   = ck_q[row] && (rd_q.cur == w_q);
              ob_res.moving = ck_q[row] && (rd_q.cur != w_q);
            end
            CMD_DETACH: begin
              ck_d[row]   = 1'b0;
              tk_d[row]   = 1'b0;
              idle_d[row] = 1'b1;
            end
            default: begin
              ob_res.moving = ck_q[row] && tk_q[row] && (rd_q.cur != rd_q.tgt);
            end
          endcase
        end
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        ob_commit.commit = 1'b1;
        state_d          = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      k_q     <= '0;
      ck_q    <= '0;
      tk_q    <= '0;
      idle_q  <= '1;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      k_q     <= k_d;
      ck_q    <= ck_d;
      tk_q    <= tk_d;
      idle_q  <= idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    upd_q <= upd_d;
    w_q   <= w_d;
    if (acc) begin
      cmd_q   <= cmd_i;
      ch_q    <= channel_i;
      spd_q   <= speed_dps_i;
      ch_ok_q <= ch_ok;
      num_q   <= num_d;
    end
  end

  // channel state memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      state_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= state_mem[mem_raddr];
    end
  end

  mcsl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  mcsl_outbuf #(
    .CHANNELS (CHANNELS)
  ) u_outbuf (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .wr_en_i          (ob_we),
    .wr_idx_i         (ob_idx),
    .wr_res_i         (ob_res),
    .commit_i         (ob_commit),
    .count_i          (k_q),
    .busy_o           (ob_busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_channel_o    (out_channel_o),
    .pulse_us_o       (pulse_us_o),
    .pulse_valid_o    (pulse_valid_o),
    .channel_moving_o (channel_moving_o),
    .all_idle_o       (all_idle_o),
    .last_o           (last_o)
  );

endmodule

[design/mcsl_div.sv]
// Restoring divider, one quotient bit per cycle, for the per-frame slew step.
// Depends on mcsl_pkg for operand widths.
module mcsl_div import mcsl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_DW-1:0] dividend_i,
  input  logic [DIV_VW-1:0] divisor_i,
  output logic              done_o,
  output logic [DIV_DW-1:0] quotient_o
);

  localparam int CW = $clog2(DIV_DW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DIV_VW-1:0] rem_q, rem_d;
  logic [DIV_VW-1:0] dvs_q, dvs_d;
  logic [DIV_DW-1:0] quo_q, quo_d;
  logic [DIV_VW:0]   rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    rem_sh = {rem_q, quo_q[DIV_DW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DIV_DW - 1);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = DIV_VW'(rem_sh - {1'b0, dvs_q});
        quo_d = {quo_q[DIV_DW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIV_VW-1:0];
        quo_d = {quo_q[DIV_DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[design/mcsl_outbuf.sv]
// Result buffer and output register: holds the results of one item and plays them out.
// Depends on mcsl_pkg for res_t and commit_t.
module mcsl_outbuf import mcsl_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_en_i,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_idx_i,
  input  res_t         wr_res_i,
  input  commit_t      commit_i,
  input  logic [$clog2(CHANNELS+1)-1:0] count_i,
  output logic         busy_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [2:0]   out_channel_o,
  output logic [11:0]  pulse_us_o,
  output logic         pulse_valid_o,
  output logic         channel_moving_o,
  output logic         all_idle_o,
  output logic         last_o
);

  localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNTW = $clog2(CHANNELS + 1);

  res_t            res_mem [CHANNELS];
  logic            busy_q;
  logic            ai_q;
  logic [CNTW-1:0] rd_q;
  logic [CNTW-1:0] cnt_q;
  logic            ov_q;
  res_t            ores_q;
  logic            oai_q;
  logic            olast_q;
  logic            load;
  logic            is_last;

  assign load    = busy_q && (!ov_q || !out_stall_i);
  assign is_last = (rd_q == cnt_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      res_mem[wr_idx_i] <= wr_res_i;
    end
    if (load) begin
      ores_q  <= res_mem[rd_q[CHW-1:0]];
      oai_q   <= ai_q;
      olast_q <= is_last;
    end
    if (commit_i.commit) begin
      ai_q  <= commit_i.all_idle;
      cnt_q <= count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rd_q   <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (commit_i.commit) begin
        busy_q <= 1'b1;
        rd_q   <= '0;
      end else if (load) begin
        rd_q <= rd_q + 1'b1;
        if (is_last) begin
          busy_q <= 1'b0;
        end
      end
      if (load) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign busy_o           = busy_q;
  assign out_valid_o      = ov_q;
  assign out_channel_o    = ores_q.ch;
  assign pulse_us_o       = ores_q.pulse;
  assign pulse_valid_o    = ores_q.valid;
  assign channel_moving_o = ores_q.moving;
  assign all_idle_o       = oai_q;
  assign last_o           = olast_q;

endmodule
